### sv/bchd_pkg.sv
`timescale 1ns / 1ps

package bchd_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DEBOUNCE_MS  = 3'd0,
    REG_HOLD_MS      = 3'd1,
    REG_CLICK_GAP_MS = 3'd2,
    REG_STEP_MS      = 3'd3,
    REG_INVERT_LEVEL = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] DEBOUNCE_MS_RST  = 16'd60;
  localparam logic [15:0] HOLD_MS_RST      = 16'd500;
  localparam logic [15:0] CLICK_GAP_MS_RST = 16'd500;
  localparam logic [15:0] STEP_MS_RST      = 16'd400;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
    logic [15:0] click_gap_ms;
    logic [15:0] step_ms;
    logic        invert_level;
  } cfg_t;

  typedef struct packed {
    logic        raw_level;
    logic [31:0] now_ms;
    logic        clear_clicks;
    logic        clear_all;
  } in_item_t;

  typedef struct packed {
    logic        pressed_now;
    logic        press_event;
    logic        release_event;
    logic        click_event;
    logic        hold_event;
    logic        holding;
    logic        clicks_ready;
    logic [7:0]  click_count;
    logic [7:0]  hold_clicks;
    logic        step_event;
    logic [7:0]  step_clicks;
  } out_item_t;

  typedef struct packed {
    logic        accepted_press;
    logic        debounce_pending;
    logic [31:0] stamp;
    logic [7:0]  running_clicks;
    logic [7:0]  published_clicks;
    logic [7:0]  clicks_before_hold;
    logic        hold_active;
    logic        step_active;
    logic        single_click_armed;
    logic        published_valid;
  } btn_state_t;

endpackage

### sv/bchd_cfg.sv
`timescale 1ns / 1ps

module bchd_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bchd_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [bchd_pkg::CfgDataWidth-1:0]    cfg_wdata,
  output bchd_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms  <= bchd_pkg::DEBOUNCE_MS_RST;
      cfg.hold_ms      <= bchd_pkg::HOLD_MS_RST;
      cfg.click_gap_ms <= bchd_pkg::CLICK_GAP_MS_RST;
      cfg.step_ms      <= bchd_pkg::STEP_MS_RST;
      cfg.invert_level <= 1'b0;
    end else if (cfg_we) begin
      // unknown indexes are dropped
      case (cfg_index)
        bchd_pkg::REG_DEBOUNCE_MS:  cfg.debounce_ms  <= cfg_wdata;
        bchd_pkg::REG_HOLD_MS:      cfg.hold_ms      <= cfg_wdata;
        bchd_pkg::REG_CLICK_GAP_MS: cfg.click_gap_ms <= cfg_wdata;
        bchd_pkg::REG_STEP_MS:      cfg.step_ms      <= cfg_wdata;
        bchd_pkg::REG_INVERT_LEVEL: cfg.invert_level <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

### sv/bchd_core.sv
`timescale 1ns / 1ps

module bchd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  bchd_pkg::cfg_t        cfg,
  input  bchd_pkg::in_item_t    item,
  output bchd_pkg::out_item_t   result
);

  bchd_pkg::btn_state_t st;
  bchd_pkg::btn_state_t st_next;

  // wrapping time check against the stamp as it stands at that point
  function automatic logic elapsed(input logic [31:0] now, input logic [31:0] stamp,
                                   input logic [15:0] limit);
    logic [31:0] diff;
    diff = now - stamp;
    return diff >= {16'd0, limit};
  endfunction

  always_comb begin
    bchd_pkg::btn_state_t s;
    logic pressed;
    logic ev_press, ev_rel, ev_click, ev_hold, ev_step;
    logic [7:0] st_clicks;

    s         = st;
    pressed   = item.raw_level ^ cfg.invert_level;
    ev_press  = 1'b0;
    ev_rel    = 1'b0;
    ev_click  = 1'b0;
    ev_hold   = 1'b0;
    ev_step   = 1'b0;
    st_clicks = 8'd0;

    if (item.clear_all) begin
      s.step_active        = 1'b0;
      s.published_valid    = 1'b0;
      s.clicks_before_hold = 8'd0;
      s.published_clicks   = 8'd0;
    end

    // debounce: first pressed tick arms, later ticks check the time
    if (pressed && !s.accepted_press) begin
      if (!s.debounce_pending) begin
        s.debounce_pending = 1'b1;
        s.stamp            = item.now_ms;
      end else if (elapsed(item.now_ms, s.stamp, cfg.debounce_ms)) begin
        s.accepted_press     = 1'b1;
        ev_press             = 1'b1;
        s.single_click_armed = 1'b1;
      end
    end else begin
      s.debounce_pending = 1'b0;
    end

    if (!pressed && s.accepted_press) begin
      s.accepted_press = 1'b0;
      if (!s.hold_active && s.running_clicks != 8'hFF) begin
        s.running_clicks = s.running_clicks + 8'd1;
      end
      s.hold_active = 1'b0;
      ev_rel        = 1'b1;
      s.stamp       = item.now_ms;
      if (s.step_active) begin
        s.published_clicks = 8'd0;
        s.running_clicks   = 8'd0;
        s.step_active      = 1'b0;
      end
      if (s.single_click_armed) begin
        s.single_click_armed = 1'b0;
        ev_click             = 1'b1;
      end
    end

    if (s.accepted_press && pressed && !s.hold_active &&
        elapsed(item.now_ms, s.stamp, cfg.hold_ms)) begin
      s.hold_active        = 1'b1;
      s.clicks_before_hold = s.running_clicks;
      ev_hold              = 1'b1;
      s.step_active        = 1'b1;
      s.single_click_armed = 1'b0;
      s.stamp              = item.now_ms;
    end

    if (!pressed && s.running_clicks != 8'd0 &&
        elapsed(item.now_ms, s.stamp, cfg.click_gap_ms)) begin
      s.published_clicks = s.running_clicks;
      s.running_clicks   = 8'd0;
      s.published_valid  = 1'b1;
    end

    if (item.clear_clicks) begin
      s.published_clicks = 8'd0;
      s.published_valid  = 1'b0;
    end

    if (s.step_active && elapsed(item.now_ms, s.stamp, cfg.step_ms)) begin
      s.stamp   = item.now_ms;
      ev_step   = 1'b1;
      st_clicks = s.running_clicks;
    end

    st_next              = s;
    result.pressed_now   = pressed;
    result.press_event   = ev_press;
    result.release_event = ev_rel;
    result.click_event   = ev_click;
    result.hold_event    = ev_hold;
    result.holding       = s.step_active;
    result.clicks_ready  = s.published_valid;
    result.click_count   = s.published_clicks;
    result.hold_clicks   = s.hold_active ? s.clicks_before_hold : 8'd0;
    result.step_event    = ev_step;
    result.step_clicks   = st_clicks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

### sv/button_click_hold_detector.sv
`timescale 1ns / 1ps
// Debounced button detector: presses, releases, clicks, multi-click bursts,
// holds and step pulses while held.
// Input stream s_*: one transfer per sampled tick, carrying the raw level, a
// wrapping millisecond timestamp and the two clear requests.
// Output stream m_*: exactly one result transfer per input transfer, in order.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user must
// write them only while the block holds no pending items, which the block does
// not enforce itself; unknown indexes are ignored. Each item passes through
// the input register, then the result register. Throughput: one item per cycle
// while the receiver takes results; the button state update is a single pass
// of compares and small counters between the input and result registers.
// Reset clears all button state and both stream stages, and loads the default
// timings (60 / 500 / 500 / 400 ms, no inversion).
// When the receiver stalls, the result register holds, the input register
// fills, and then s_tready drops until the result is taken.
module button_click_hold_detector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // raw_level[0], now_ms[32:1], clear_clicks[33], clear_all[34], zero fill
  input  logic [bchd_pkg::InDataWidth-1:0]       s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // pressed_now[0], press_event[1], release_event[2], click_event[3],
  // hold_event[4], holding[5], clicks_ready[6], click_count[14:7],
  // hold_clicks[22:15], step_event[23], step_clicks[31:24]
  output logic [bchd_pkg::OutDataWidth-1:0]      m_tdata,
  input  logic                                   cfg_we,
  input  logic [bchd_pkg::CfgIdxWidth-1:0]       cfg_index,
  input  logic [bchd_pkg::CfgDataWidth-1:0]      cfg_wdata
);

  bchd_pkg::cfg_t      cfg;
  bchd_pkg::in_item_t  in_reg;
  bchd_pkg::out_item_t result;
  bchd_pkg::out_item_t out_reg;
  logic                in_valid;
  logic                advance;

  bchd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bchd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .item    (in_reg),
    .result  (result)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_reg.raw_level    <= s_tdata[0];
      in_reg.now_ms       <= s_tdata[32:1];
      in_reg.clear_clicks <= s_tdata[33];
      in_reg.clear_all    <= s_tdata[34];
    end
    if (advance) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {out_reg.step_clicks, out_reg.step_event, out_reg.hold_clicks,
                    out_reg.click_count, out_reg.clicks_ready, out_reg.holding,
                    out_reg.hold_event, out_reg.click_event, out_reg.release_event,
                    out_reg.press_event, out_reg.pressed_now};

endmodule

### sv/bchd_checker.sv
`timescale 1ns / 1ps

module bchd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [bchd_pkg::OutDataWidth-1:0]   m_tdata
);

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a press is only accepted on a pressed tick
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0] && !m_tdata[2])
    else $error("press event without pressed level");

  // a new hold always starts stepping
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[5] && !m_tdata[3])
    else $error("hold event without holding");

  // step count is only carried with a step pulse
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[23] |-> m_tdata[31:24] == 8'd0)
    else $error("step clicks without step event");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
